// ===== design/rqcg_pkg.sv =====
// shared constants, types and sine table builder for the rotating quad corner generator
package rqcg_pkg;

  localparam int SINE_ADDR_BITS = 8;
  localparam int QTR_N          = 1 << SINE_ADDR_BITS;
  localparam int ROM_AW         = SINE_ADDR_BITS + 1;
  localparam int ANGLE_W        = 16;
  localparam int COORD_IN_W     = 12;
  localparam int COORD_OUT_W    = 14;
  localparam int PROD_W         = 29;
  localparam int SUM_W          = PROD_W + 1;

  localparam logic [ANGLE_W-1:0] STEP_RESET   = 16'd522;
  localparam logic [63:0]        HALF_PI_Q30  = 64'd1686629713;
  localparam logic [63:0]        Q15_MAX      = 64'd32767;

  typedef logic [ANGLE_W-1:0]        angle_t;
  typedef logic [ROM_AW-1:0]         rom_addr_t;
  typedef logic [15:0]               q15_t;
  typedef logic signed [15:0]        trig_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [SUM_W-1:0]   offs_t;
  typedef logic [15:0]               sine_tab_t [QTR_N+1];

  // odd taylor series up to x^11 in q2.30, scaled to q1.15
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t   tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    for (int k = 0; k <= QTR_N; k++) begin
      x    = (64'(k) * HALF_PI_Q30) >> SINE_ADDR_BITS;
      x2   = (x * x) >> 30;
      sum  = x;
      term = ((x * x2) >> 30) / 64'd6;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - term;
      v    = (sum * Q15_MAX + (64'd1 << 29)) >> 30;
      if (v > Q15_MAX) begin
        v = Q15_MAX;
      end
      tab[k] = v[15:0];
    end
    return tab;
  endfunction

endpackage

// ===== design/rqcg_sine_rom.sv =====
// quarter-wave sine rom with two synchronous read ports
module rqcg_sine_rom (
  input  logic               clk,
  input  logic               rd_en,
  input  rqcg_pkg::rom_addr_t sin_addr,
  input  rqcg_pkg::rom_addr_t cos_addr,
  output rqcg_pkg::q15_t     sin_data,
  output rqcg_pkg::q15_t     cos_data
);
  import rqcg_pkg::*;

  localparam sine_tab_t SineTab = build_sine_tab();

  q15_t sin_data_r;
  q15_t cos_data_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      sin_data_r <= SineTab[sin_addr];
      cos_data_r <= SineTab[cos_addr];
    end
  end

  assign sin_data = sin_data_r;
  assign cos_data = cos_data_r;

endmodule

// ===== design/rotating_quad_corner_generator.sv =====
// an accepted input beat passes stage 1, stage 2, stage 3 and the output register on its way to out_valid
// throughput: one beat per cycle, a stall at the output backs up stage by stage
// sin and cos come from a synchronous two-port quarter-wave rom read in the accept cycle
// reset: running angle 0, angle_step 522, all pipeline stages and the output empty
// top level: rotating quad corner generator
module rotating_quad_corner_generator (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic [15:0]             cfg_wr_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [11:0]      in_center_x,
  input  logic signed [11:0]      in_center_y,
  input  logic [11:0]             in_width,
  input  logic [11:0]             in_height,
  input  logic                    in_turn_left,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [13:0]      out_corner0_x,
  output logic signed [13:0]      out_corner0_y,
  output logic signed [13:0]      out_corner1_x,
  output logic signed [13:0]      out_corner1_y,
  output logic signed [13:0]      out_corner2_x,
  output logic signed [13:0]      out_corner2_y,
  output logic signed [13:0]      out_corner3_x,
  output logic signed [13:0]      out_corner3_y
);
  import rqcg_pkg::*;

  typedef logic signed [COORD_IN_W-1:0]  cin_t;
  typedef logic signed [COORD_OUT_W-1:0] cout_t;
  typedef logic [COORD_IN_W-1:0]         size_t;

  // round half up then clamp to the output range
  function automatic cout_t corner(input cin_t ctr, input offs_t off);
    logic signed [31:0] acc;
    logic signed [15:0] r;
    acc = 32'(signed'({ctr, 16'h0000})) + 32'(off) + 32'sd32768;
    r   = acc[31:16];
    if (r < -16'sd8192) begin
      return -14'sd8192;
    end else if (r > 16'sd8191) begin
      return 14'sd8191;
    end else begin
      return r[COORD_OUT_W-1:0];
    end
  endfunction

  // handshake chain
  logic v1_r, v2_r, v3_r, out_valid_r;
  logic go1, go2, go3, go_out, accept;

  assign go_out   = !out_valid_r || !out_stall;
  assign go3      = !v3_r || go_out;
  assign go2      = !v2_r || go3;
  assign go1      = !v1_r || go2;
  assign in_stall = !go1;
  assign accept   = in_valid && go1;

  // angle accumulator and rom addressing
  angle_t step_r, angle_r, angle_nxt;
  logic [1:0] quad_s, quad_c;
  logic [SINE_ADDR_BITS-1:0] p;
  rom_addr_t sin_addr, cos_addr;
  q15_t sin_t, cos_t;

  assign angle_nxt = angle_r + step_r;
  assign quad_s    = angle_nxt[ANGLE_W-1 -: 2];
  assign quad_c    = quad_s + 2'd1;
  assign p         = angle_nxt[ANGLE_W-3 -: SINE_ADDR_BITS];
  // odd quadrants run the table backwards
  assign sin_addr  = quad_s[0] ? rom_addr_t'(QTR_N) - {1'b0, p} : {1'b0, p};
  assign cos_addr  = quad_c[0] ? rom_addr_t'(QTR_N) - {1'b0, p} : {1'b0, p};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= STEP_RESET;
      angle_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        step_r <= cfg_wr_data;
      end
      if (accept) begin
        angle_r <= angle_nxt;
      end
    end
  end

  rqcg_sine_rom u_rom (
    .clk      (clk),
    .rd_en    (go1),
    .sin_addr (sin_addr),
    .cos_addr (cos_addr),
    .sin_data (sin_t),
    .cos_data (cos_t)
  );

  // stage 1: rom output, payload
  cin_t  s1_cx_r, s1_cy_r;
  size_t s1_w_r, s1_h_r;
  logic  s1_left_r, s1_neg_s_r, s1_neg_c_r;

  always_ff @(posedge clk) begin
    if (go1) begin
      s1_cx_r    <= in_center_x;
      s1_cy_r    <= in_center_y;
      s1_w_r     <= in_width;
      s1_h_r     <= in_height;
      s1_left_r  <= in_turn_left;
      s1_neg_s_r <= quad_s[1];
      s1_neg_c_r <= quad_c[1];
    end
  end

  // left turn is the same rotation with sine negated
  trig_t s_val, c_val;
  logic signed [COORD_IN_W:0] w_s, h_s;
  assign s_val = (s1_neg_s_r ^ s1_left_r) ? -trig_t'(sin_t) : trig_t'(sin_t);
  assign c_val = s1_neg_c_r ? -trig_t'(cos_t) : trig_t'(cos_t);
  assign w_s   = signed'({1'b0, s1_w_r});
  assign h_s   = signed'({1'b0, s1_h_r});

  // stage 2: products
  prod_t wc_r, hs_r, hc_r, ws_r;
  cin_t  s2_cx_r, s2_cy_r;

  always_ff @(posedge clk) begin
    if (go2) begin
      wc_r    <= w_s * c_val;
      hs_r    <= h_s * s_val;
      hc_r    <= h_s * c_val;
      ws_r    <= w_s * s_val;
      s2_cx_r <= s1_cx_r;
      s2_cy_r <= s1_cy_r;
    end
  end

  // stage 3: rotated offsets
  offs_t x1_r, y1_r, x2_r, y2_r;
  cin_t  s3_cx_r, s3_cy_r;

  always_ff @(posedge clk) begin
    if (go3) begin
      x1_r    <= offs_t'(wc_r) - offs_t'(hs_r);
      y1_r    <= offs_t'(hc_r) + offs_t'(ws_r);
      x2_r    <= offs_t'(wc_r) + offs_t'(hs_r);
      y2_r    <= offs_t'(hc_r) - offs_t'(ws_r);
      s3_cx_r <= s2_cx_r;
      s3_cy_r <= s2_cy_r;
    end
  end

  // output register
  cout_t c0x_r, c0y_r, c1x_r, c1y_r, c2x_r, c2y_r, c3x_r, c3y_r;

  always_ff @(posedge clk) begin
    if (go_out) begin
      c0x_r <= corner(s3_cx_r, -x1_r);
      c0y_r <= corner(s3_cy_r, -y1_r);
      c1x_r <= corner(s3_cx_r, x2_r);
      c1y_r <= corner(s3_cy_r, -y2_r);
      c2x_r <= corner(s3_cx_r, -x2_r);
      c2y_r <= corner(s3_cy_r, y2_r);
      c3x_r <= corner(s3_cx_r, x1_r);
      c3y_r <= corner(s3_cy_r, y1_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (go1) begin
        v1_r <= accept;
      end
      if (go2) begin
        v2_r <= v1_r;
      end
      if (go3) begin
        v3_r <= v2_r;
      end
      if (go_out) begin
        out_valid_r <= v3_r;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_corner0_x = c0x_r;
  assign out_corner0_y = c0y_r;
  assign out_corner1_x = c1x_r;
  assign out_corner1_y = c1y_r;
  assign out_corner2_x = c2x_r;
  assign out_corner2_y = c2y_r;
  assign out_corner3_x = c3x_r;
  assign out_corner3_y = c3y_r;

endmodule

// ===== sim/tb_rotating_quad_corner_generator.sv =====
// self-checking testbench for the rotating quad corner generator
`timescale 1ns / 100ps
module tb_rotating_quad_corner_generator;

  localparam int          TAB_BITS      = 8;
  localparam int          TAB_QTR       = 1 << TAB_BITS;
  localparam int          PIPE_LAT      = 4;
  localparam int          CYCLE_LIMIT   = 400000;
  localparam int          N_PHASES      = 8;
  localparam int          PHASE_RECTS   = 150;
  localparam int          MAX_PRINTS    = 40;
  localparam logic [15:0] STEP_AT_RESET = 16'd522;
  localparam logic [15:0] QUARTER_TURN  = 16'd16384;

  typedef struct packed {
    logic signed [11:0] cx;
    logic signed [11:0] cy;
    logic [11:0]        w;
    logic [11:0]        h;
    logic               left;
  } rect_t;

  typedef struct packed {
    logic signed [13:0] c0x;
    logic signed [13:0] c0y;
    logic signed [13:0] c1x;
    logic signed [13:0] c1y;
    logic signed [13:0] c2x;
    logic signed [13:0] c2y;
    logic signed [13:0] c3x;
    logic signed [13:0] c3y;
  } corners_t;

  logic               clk           = 1'b0;
  logic               rst_n         = 1'b0;
  logic               cfg_wr_en     = 1'b0;
  logic [15:0]        cfg_wr_data   = 16'd0;
  logic               in_valid      = 1'b0;
  logic               in_stall;
  logic signed [11:0] in_center_x   = 12'sd0;
  logic signed [11:0] in_center_y   = 12'sd0;
  logic [11:0]        in_width      = 12'd0;
  logic [11:0]        in_height     = 12'd0;
  logic               in_turn_left  = 1'b0;
  logic               out_valid;
  logic               out_stall     = 1'b0;
  logic signed [13:0] out_corner0_x;
  logic signed [13:0] out_corner0_y;
  logic signed [13:0] out_corner1_x;
  logic signed [13:0] out_corner1_y;
  logic signed [13:0] out_corner2_x;
  logic signed [13:0] out_corner2_y;
  logic signed [13:0] out_corner3_x;
  logic signed [13:0] out_corner3_y;

  rect_t       rect_pending [$];
  corners_t    corner_q [$];
  int          quarter_sine [TAB_QTR+1];
  logic [15:0] cur_angle;
  logic [15:0] step_now;
  int          send_idle_pct = 0;
  int          stall_pct     = 0;
  int          cycles        = 0;
  int          n_err         = 0;
  int          n_sent        = 0;
  int          n_checked     = 0;

  rotating_quad_corner_generator dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_center_x   (in_center_x),
    .in_center_y   (in_center_y),
    .in_width      (in_width),
    .in_height     (in_height),
    .in_turn_left  (in_turn_left),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_corner0_x (out_corner0_x),
    .out_corner0_y (out_corner0_y),
    .out_corner1_x (out_corner1_x),
    .out_corner1_y (out_corner1_y),
    .out_corner2_x (out_corner2_x),
    .out_corner2_y (out_corner2_y),
    .out_corner3_x (out_corner3_x),
    .out_corner3_y (out_corner3_y)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // q1.15 sine of k/TAB_QTR quarter turns, odd series to x^11 in q2.30
  function automatic int taylor_sine(int k);
    bit [63:0] x;
    bit [63:0] x2;
    bit [63:0] term;
    bit [63:0] acc;
    bit [63:0] v;
    x    = (64'(k) * 64'd1686629713) / 64'(TAB_QTR);
    x2   = (x * x) >> 30;
    term = x;
    acc  = x;
    for (int n = 3; n <= 11; n += 2) begin
      term = ((term * x2) >> 30) / 64'((n - 1) * n);
      if ((((n - 1) / 2) % 2) == 1) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    v = (acc * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return int'(v);
  endfunction

  function automatic int q15_sine(logic [15:0] a);
    int p;
    int mag;
    p   = int'(a[13:14-TAB_BITS]);
    mag = a[14] ? quarter_sine[TAB_QTR - p] : quarter_sine[p];
    return a[15] ? -mag : mag;
  endfunction

  // offsets are in 2^-16 pixel; round half up, then clamp to the output range
  function automatic logic signed [13:0] place_corner(longint center, longint off);
    longint r;
    r = (center * 65536 + off + 32768) >>> 16;
    if (r < -8192) begin
      r = -8192;
    end
    if (r > 8191) begin
      r = 8191;
    end
    return 14'(r);
  endfunction

  // advances the angle, then rotates the half-size vector about the center
  function automatic corners_t rotate_rect(rect_t r);
    corners_t q;
    longint   cx;
    longint   cy;
    longint   w;
    longint   h;
    longint   s;
    longint   c;
    longint   x1;
    longint   y1;
    longint   x2;
    longint   y2;
    logic [15:0] cos_angle;
    cur_angle = cur_angle + step_now;
    cos_angle = cur_angle + QUARTER_TURN;
    cx = longint'($signed(r.cx));
    cy = longint'($signed(r.cy));
    w  = longint'(r.w);
    h  = longint'(r.h);
    s  = longint'(q15_sine(cur_angle));
    c  = longint'(q15_sine(cos_angle));
    if (r.left) begin
      x1 = w * c + h * s;
      y1 = h * c - w * s;
      x2 = w * c - h * s;
      y2 = h * c + w * s;
    end else begin
      x1 = w * c - h * s;
      y1 = h * c + w * s;
      x2 = w * c + h * s;
      y2 = h * c - w * s;
    end
    q.c0x = place_corner(cx, -x1);
    q.c0y = place_corner(cy, -y1);
    q.c1x = place_corner(cx, x2);
    q.c1y = place_corner(cy, -y2);
    q.c2x = place_corner(cx, -x2);
    q.c2y = place_corner(cy, y2);
    q.c3x = place_corner(cx, x1);
    q.c3y = place_corner(cy, y1);
    return q;
  endfunction

  function automatic rect_t mk_rect(int cx, int cy, int w, int h, bit left);
    rect_t r;
    r.cx   = 12'(cx);
    r.cy   = 12'(cy);
    r.w    = 12'(w);
    r.h    = 12'(h);
    r.left = left;
    return r;
  endfunction

  function automatic rect_t rand_rect();
    rect_t r;
    r.cx   = 12'($urandom);
    r.cy   = 12'($urandom);
    r.w    = 12'($urandom);
    r.h    = 12'($urandom);
    r.left = 1'($urandom);
    case ($urandom_range(7))
      0: begin
        // pin the centers and sizes to the edges of the field ranges
        r.cx = $urandom_range(1) ? 12'h7FF : 12'h800;
        r.cy = $urandom_range(1) ? 12'h7FF : 12'h800;
        r.w  = $urandom_range(1) ? 12'hFFF : 12'h000;
        r.h  = $urandom_range(1) ? 12'hFFF : 12'h000;
      end
      1: begin
        // tiny sizes exercise half-pixel rounding
        r.w = 12'($urandom_range(3));
        r.h = 12'($urandom_range(3));
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    if (n_err < MAX_PRINTS) begin
      $display("mismatch at cycle %0d: %s", cycles, msg);
    end
    n_err++;
  endtask

  task automatic check_field(string name, logic signed [13:0] got, logic signed [13:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    end
  endtask

  // settle at the falling edge so that every queue and handshake is coherent
  task automatic wait_drained();
    @(negedge clk);
    while (rect_pending.size() != 0 || in_valid || corner_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (PIPE_LAT) @(posedge clk);
  endtask

  task automatic write_step(logic [15:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    step_now     = v;
  endtask

  function automatic logic [15:0] phase_step(int ph);
    case (ph)
      1:       return 16'd0;
      2:       return 16'hFFFF;
      3:       return QUARTER_TURN;
      4:       return 16'd1;
      5:       return 16'($urandom);
      6:       return 16'h8000 | 16'($urandom_range(255));
      default: return STEP_AT_RESET;
    endcase
  endfunction

  // driver: a beat holds until accepted, then the next one may follow
  always @(posedge clk) begin
    rect_t r;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (rect_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        r = rect_pending.pop_front();
        in_center_x  <= r.cx;
        in_center_y  <= r.cy;
        in_width     <= r.w;
        in_height    <= r.h;
        in_turn_left <= r.left;
        in_valid     <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // monitor: predict on every accepted input beat, check every accepted output beat
  always @(posedge clk) begin
    corners_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        corner_q.push_back(rotate_rect({in_center_x, in_center_y, in_width, in_height,
                                        in_turn_left}));
        n_sent++;
      end
      if (out_valid && !out_stall) begin
        if (corner_q.size() == 0) begin
          report_mismatch("output beat with no request pending");
        end else begin
          want = corner_q.pop_front();
          n_checked++;
          check_field("corner0_x", out_corner0_x, want.c0x);
          check_field("corner0_y", out_corner0_y, want.c0y);
          check_field("corner1_x", out_corner1_x, want.c1x);
          check_field("corner1_y", out_corner1_y, want.c1y);
          check_field("corner2_x", out_corner2_x, want.c2x);
          check_field("corner2_y", out_corner2_y, want.c2y);
          check_field("corner3_x", out_corner3_x, want.c3x);
          check_field("corner3_y", out_corner3_y, want.c3y);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, corner_q.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    for (int k = 0; k <= TAB_QTR; k++) begin
      quarter_sine[k] = taylor_sine(k);
    end
    cur_angle = 16'd0;
    step_now  = STEP_AT_RESET;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // field extremes, both directions, half-pixel sizes, alternating bit patterns
    rect_pending.push_back(mk_rect(0, 0, 0, 0, 1'b0));
    rect_pending.push_back(mk_rect(0, 0, 0, 0, 1'b1));
    rect_pending.push_back(mk_rect(-2048, -2048, 4095, 4095, 1'b0));
    rect_pending.push_back(mk_rect(-2048, -2048, 4095, 4095, 1'b1));
    rect_pending.push_back(mk_rect(2047, 2047, 4095, 4095, 1'b0));
    rect_pending.push_back(mk_rect(2047, 2047, 4095, 4095, 1'b1));
    rect_pending.push_back(mk_rect(2047, -2048, 4095, 0, 1'b0));
    rect_pending.push_back(mk_rect(-2048, 2047, 0, 4095, 1'b1));
    rect_pending.push_back(mk_rect(-1, 1, 1, 1, 1'b0));
    rect_pending.push_back(mk_rect(1, -1, 1, 3, 1'b1));
    rect_pending.push_back(mk_rect(0, 0, 4094, 1, 1'b0));
    rect_pending.push_back(mk_rect(0, 0, 1, 4094, 1'b1));
    rect_pending.push_back(mk_rect(1365, -1366, 1365, 2730, 1'b1));
    rect_pending.push_back(mk_rect(-1366, 1365, 2730, 1365, 1'b0));
    rect_pending.push_back(mk_rect(100, -100, 200, 50, 1'b0));
    rect_pending.push_back(mk_rect(100, -100, 200, 50, 1'b1));
    wait_drained();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph != 0) begin
        write_step(phase_step(ph));
      end
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 63; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 63; end
        default: begin send_idle_pct = 23; stall_pct = 23; end
      endcase
      for (int i = 0; i < PHASE_RECTS; i++) begin
        rect_pending.push_back(rand_rect());
      end
      wait_drained();
    end
    stall_pct = 0;
    repeat (4 * PIPE_LAT) @(posedge clk);

    $display("%0d rectangles sent over %0d angle step settings and four idle patterns",
             n_sent, N_PHASES);
    $display("%0d corner sets compared, %0d mismatches", n_checked, n_err);
    if (n_err == 0 && corner_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/rqcg_pkg.sv
design/rqcg_sine_rom.sv
design/rotating_quad_corner_generator.sv
sim/tb_rotating_quad_corner_generator.sv
